// ===== rtl/tcau_pkg.sv =====
package tcau_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int SIZE_WIDTH_DEF  = 8;
	localparam int STEP_BITS       = 4;
	localparam int PADDR_WIDTH     = 5;
	localparam int PDATA_WIDTH     = 32;
	localparam int CHUNK_SIZE_RST  = 13;
	localparam int RING_CHUNKS_RST = 9;

	typedef enum logic [2:0] {
		REG_SIZE_X,
		REG_SIZE_Y,
		REG_SIZE_Z,
		REG_RING_X,
		REG_RING_Y,
		REG_RING_Z
	} cfg_reg_t;

	function automatic int step_count(input int bits);
		return (bits + STEP_BITS - 1) / STEP_BITS;
	endfunction

	function automatic int sum_width(input int coord_w, input int size_w);
		return ((coord_w > size_w) ? coord_w : size_w) + 1;
	endfunction

	function automatic int pipe_depth(input int coord_w, input int size_w);
		return step_count(coord_w - 1) + step_count(sum_width(coord_w, size_w) - 1) + 2;
	endfunction

endpackage

// ===== rtl/tcau_if.sv =====
interface tcau_coord_if import tcau_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] coord_x;
	logic signed [COORD_WIDTH-1:0] coord_y;
	logic signed [COORD_WIDTH-1:0] coord_z;

	modport source (output valid, output coord_x, output coord_y, output coord_z, input ready);
	modport sink (input valid, input coord_x, input coord_y, input coord_z, output ready);
endinterface

interface tcau_addr_if import tcau_pkg::*; #(
	parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
);
	logic                  valid;
	logic                  ready;
	logic [SIZE_WIDTH-1:0] slot_x;
	logic [SIZE_WIDTH-1:0] slot_y;
	logic [SIZE_WIDTH-1:0] slot_z;
	logic [SIZE_WIDTH-1:0] offset_x;
	logic [SIZE_WIDTH-1:0] offset_y;
	logic [SIZE_WIDTH-1:0] offset_z;

	modport source (
		output valid, output slot_x, output slot_y, output slot_z,
		output offset_x, output offset_y, output offset_z, input ready
	);
	modport sink (
		input valid, input slot_x, input slot_y, input slot_z,
		input offset_x, input offset_y, input offset_z, output ready
	);
endinterface

// ===== rtl/tcau_axis.sv =====
module tcau_axis import tcau_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int SIZE_WIDTH  = SIZE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          advance,
	input  logic signed [COORD_WIDTH-1:0] coord,
	input  logic        [SIZE_WIDTH-1:0]  chunk_size,
	input  logic        [SIZE_WIDTH-1:0]  ring_chunks,
	output logic        [SIZE_WIDTH-1:0]  slot,
	output logic        [SIZE_WIDTH-1:0]  offset
);

	localparam int MAG_W = COORD_WIDTH - 1;
	localparam int SUM_W = sum_width(COORD_WIDTH, SIZE_WIDTH);
	localparam int U2_W  = SUM_W - 1;
	localparam int P1    = step_count(MAG_W);
	localparam int P2    = step_count(U2_W);

	logic [SIZE_WIDTH-1:0] size_eff;
	logic [SIZE_WIDTH-1:0] ring_eff;

	assign size_eff = (chunk_size == '0) ? SIZE_WIDTH'(1) : chunk_size;
	assign ring_eff = (ring_chunks == '0) ? SIZE_WIDTH'(1) : ring_chunks;

	// coordinate division: magnitude of a, or of -a-1 when negative
	logic [MAG_W-1:0]      qd_s  [P1+1];
	logic [SIZE_WIDTH-1:0] rem_s [P1+1];
	logic                  neg_s [P1+1];

	assign qd_s[0]  = coord[COORD_WIDTH-1] ? ~coord[MAG_W-1:0] : coord[MAG_W-1:0];
	assign rem_s[0] = '0;
	assign neg_s[0] = coord[COORD_WIDTH-1];

	for (genvar i = 0; i < P1; i++) begin : g_div
		logic [MAG_W-1:0]      qd_n;
		logic [SIZE_WIDTH-1:0] rem_n;

		always_comb begin
			logic [SIZE_WIDTH:0] trial;
			trial = '0;
			qd_n  = qd_s[i];
			rem_n = rem_s[i];
			for (int j = 0; j < STEP_BITS; j++) begin
				if (i * STEP_BITS + j < MAG_W) begin
					trial = {rem_n, qd_n[MAG_W-1]};
					qd_n  = {qd_n[MAG_W-2:0], 1'b0};
					if (trial >= {1'b0, size_eff}) begin
						rem_n   = SIZE_WIDTH'(trial - {1'b0, size_eff});
						qd_n[0] = 1'b1;
					end else begin
						rem_n = trial[SIZE_WIDTH-1:0];
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				qd_s[i+1]  <= qd_n;
				rem_s[i+1] <= rem_n;
				neg_s[i+1] <= neg_s[i];
			end
		end
	end

	// floor correction, ring offset, magnitude for the wrap
	logic [COORD_WIDTH-1:0] quot;
	logic [SUM_W-1:0]       sum;
	logic [SIZE_WIDTH-1:0]  off_fix;

	logic [U2_W-1:0]       md_s   [P2+1];
	logic [SIZE_WIDTH-1:0] mrem_s [P2+1];
	logic                  mneg_s [P2+1];
	logic [SIZE_WIDTH-1:0] off_s  [P2+1];

	always_comb begin
		quot    = neg_s[P1] ? ~{1'b0, qd_s[P1]} : {1'b0, qd_s[P1]};
		sum     = {{(SUM_W-COORD_WIDTH){quot[COORD_WIDTH-1]}}, quot}
			+ SUM_W'(ring_eff >> 1);
		off_fix = neg_s[P1] ? (size_eff - SIZE_WIDTH'(1) - rem_s[P1]) : rem_s[P1];
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			md_s[0]   <= sum[SUM_W-1] ? ~sum[U2_W-1:0] : sum[U2_W-1:0];
			mrem_s[0] <= '0;
			mneg_s[0] <= sum[SUM_W-1];
			off_s[0]  <= off_fix;
		end
	end

	for (genvar i = 0; i < P2; i++) begin : g_wrap
		logic [U2_W-1:0]       md_n;
		logic [SIZE_WIDTH-1:0] mrem_n;

		always_comb begin
			logic [SIZE_WIDTH:0] trial;
			trial  = '0;
			md_n   = md_s[i];
			mrem_n = mrem_s[i];
			for (int j = 0; j < STEP_BITS; j++) begin
				if (i * STEP_BITS + j < U2_W) begin
					trial = {mrem_n, md_n[U2_W-1]};
					md_n  = {md_n[U2_W-2:0], 1'b0};
					if (trial >= {1'b0, ring_eff}) begin
						mrem_n = SIZE_WIDTH'(trial - {1'b0, ring_eff});
					end else begin
						mrem_n = trial[SIZE_WIDTH-1:0];
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				md_s[i+1]   <= md_n;
				mrem_s[i+1] <= mrem_n;
				mneg_s[i+1] <= mneg_s[i];
				off_s[i+1]  <= off_s[i];
			end
		end
	end

	logic [SIZE_WIDTH-1:0] slot_q;
	logic [SIZE_WIDTH-1:0] offset_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			slot_q   <= mneg_s[P2] ? (ring_eff - SIZE_WIDTH'(1) - mrem_s[P2]) : mrem_s[P2];
			offset_q <= off_s[P2];
		end
	end

	assign slot   = slot_q;
	assign offset = offset_q;

endmodule

// ===== rtl/toroidal_chunk_address_unit.sv =====
// Maps a signed voxel coordinate onto a wraparound ring of chunks, per axis:
// slot = floor(coord / chunk_size) + ring_chunks / 2 wrapped into the ring, and
// offset = floored remainder of coord by chunk_size. A chunk_size or ring_chunks
// register holding zero acts as one. The datapath is a pipeline of restoring
// dividers retiring four bits per stage, and one coordinate is taken every
// cycle. When the result is not taken the whole pipeline holds and intake stops.
// Registers sit at byte addresses 0, 4, ... 20 in the order chunk_size_x/y/z,
// ring_chunks_x/y/z; the user must write them only while no transfer is in flight,
// and the block itself does not enforce this.
module toroidal_chunk_address_unit import tcau_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int SIZE_WIDTH  = SIZE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PADDR_WIDTH-1:0] paddr,
	input  logic [PDATA_WIDTH-1:0] pwdata,
	output logic [PDATA_WIDTH-1:0] prdata,
	output logic                   pready,
	tcau_coord_if.sink             coord,
	tcau_addr_if.source            addr
);

	localparam int LAT = pipe_depth(COORD_WIDTH, SIZE_WIDTH);

	logic [SIZE_WIDTH-1:0] size_x_q, size_y_q, size_z_q;
	logic [SIZE_WIDTH-1:0] ring_x_q, ring_y_q, ring_z_q;
	logic [SIZE_WIDTH-1:0] wdata;
	cfg_reg_t              reg_idx;
	logic                  cfg_write;

	assign pready    = 1'b1;
	assign reg_idx   = cfg_reg_t'(paddr[PADDR_WIDTH-1:2]);
	assign wdata     = pwdata[SIZE_WIDTH-1:0];
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_WIDTH'(CHUNK_SIZE_RST);
			size_y_q <= SIZE_WIDTH'(CHUNK_SIZE_RST);
			size_z_q <= SIZE_WIDTH'(CHUNK_SIZE_RST);
			ring_x_q <= SIZE_WIDTH'(RING_CHUNKS_RST);
			ring_y_q <= SIZE_WIDTH'(RING_CHUNKS_RST);
			ring_z_q <= SIZE_WIDTH'(RING_CHUNKS_RST);
		end else if (cfg_write) begin
			case (reg_idx)
				REG_SIZE_X: size_x_q <= wdata;
				REG_SIZE_Y: size_y_q <= wdata;
				REG_SIZE_Z: size_z_q <= wdata;
				REG_RING_X: ring_x_q <= wdata;
				REG_RING_Y: ring_y_q <= wdata;
				REG_RING_Z: ring_z_q <= wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SIZE_X: prdata = PDATA_WIDTH'(size_x_q);
			REG_SIZE_Y: prdata = PDATA_WIDTH'(size_y_q);
			REG_SIZE_Z: prdata = PDATA_WIDTH'(size_z_q);
			REG_RING_X: prdata = PDATA_WIDTH'(ring_x_q);
			REG_RING_Y: prdata = PDATA_WIDTH'(ring_y_q);
			REG_RING_Z: prdata = PDATA_WIDTH'(ring_z_q);
			default:    prdata = '0;
		endcase
	end

	// stall everything together while the output holds an untaken transfer
	logic           advance;
	logic [LAT-1:0] vld_s;

	assign advance     = !vld_s[LAT-1] || addr.ready;
	assign coord.ready = advance;
	assign addr.valid  = vld_s[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (advance) begin
			vld_s <= {vld_s[LAT-2:0], coord.valid};
		end
	end

	tcau_axis #(.COORD_WIDTH(COORD_WIDTH), .SIZE_WIDTH(SIZE_WIDTH)) u_axis_x (
		.clk         (clk),
		.advance     (advance),
		.coord       (coord.coord_x),
		.chunk_size  (size_x_q),
		.ring_chunks (ring_x_q),
		.slot        (addr.slot_x),
		.offset      (addr.offset_x)
	);

	tcau_axis #(.COORD_WIDTH(COORD_WIDTH), .SIZE_WIDTH(SIZE_WIDTH)) u_axis_y (
		.clk         (clk),
		.advance     (advance),
		.coord       (coord.coord_y),
		.chunk_size  (size_y_q),
		.ring_chunks (ring_y_q),
		.slot        (addr.slot_y),
		.offset      (addr.offset_y)
	);

	tcau_axis #(.COORD_WIDTH(COORD_WIDTH), .SIZE_WIDTH(SIZE_WIDTH)) u_axis_z (
		.clk         (clk),
		.advance     (advance),
		.coord       (coord.coord_z),
		.chunk_size  (size_z_q),
		.ring_chunks (ring_z_q),
		.slot        (addr.slot_z),
		.offset      (addr.offset_z)
	);

endmodule

// ===== rtl/tcau_checker.sv =====
module tcau_checker import tcau_pkg::*; #(
	parameter int DEPTH = pipe_depth(COORD_WIDTH_DEF, SIZE_WIDTH_DEF)
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);

	localparam int CNT_W = $clog2(DEPTH + 2);

	logic [CNT_W-1:0] inflight_q;
	logic             in_xfer;
	logic             out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			inflight_q <= inflight_q + CNT_W'(1);
		end else if (out_xfer && !in_xfer) begin
			inflight_q <= inflight_q - CNT_W'(1);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before transfer");

	a_free_output_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("intake closed while output is free");

	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("result without a pending input transfer");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(DEPTH))
		else $error("more items in flight than pipeline stages");

endmodule

bind toroidal_chunk_address_unit tcau_checker #(
	.DEPTH (tcau_pkg::pipe_depth(COORD_WIDTH, SIZE_WIDTH))
) u_tcau_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (coord.valid),
	.in_ready  (coord.ready),
	.out_valid (addr.valid),
	.out_ready (addr.ready)
);

// ===== bench/toroidal_chunk_address_unit_test.sv =====
module toroidal_chunk_address_unit_test;
	import tcau_pkg::*;

	localparam int CW       = COORD_WIDTH_DEF;
	localparam int SW       = SIZE_WIDTH_DEF;
	localparam int PIPE_LAT = pipe_depth(COORD_WIDTH_DEF, SIZE_WIDTH_DEF);
	localparam int N_ROWS   = 47;
	localparam int SETTINGS_PER_PHASE = 5;
	localparam int ITEMS_PER_SETTING  = 30;

	localparam logic [2:0] REG_NONE_A = 3'd6;
	localparam logic [2:0] REG_NONE_B = 3'd7;

	localparam logic signed [CW-1:0] C_MAX = 24'sh7FFFFF;
	localparam logic signed [CW-1:0] C_MIN = 24'sh800000;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		logic [SW-1:0] slot_x;
		logic [SW-1:0] slot_y;
		logic [SW-1:0] slot_z;
		logic [SW-1:0] offset_x;
		logic [SW-1:0] offset_y;
		logic [SW-1:0] offset_z;
	} chunk_addr_t;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t     kind;
		logic [2:0]    reg_idx;
		logic [31:0]   wdata;
		coord_t        cx;
		coord_t        cy;
		coord_t        cz;
		logic          typed;
		chunk_addr_t   want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_WIDTH-1:0] paddr;
	logic [PDATA_WIDTH-1:0] pwdata;
	logic [PDATA_WIDTH-1:0] prdata;
	logic pready;

	tcau_coord_if coord_bus ();
	tcau_addr_if  addr_bus ();

	toroidal_chunk_address_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coord   (coord_bus),
		.addr    (addr_bus)
	);

	always #6 clk = ~clk;

	logic [SW-1:0] chunk_len [3];
	logic [SW-1:0] ring_len [3];

	chunk_addr_t addr_exp_q [$];
	int src_idle;
	int snk_idle;
	int coords_sent;
	int addrs_checked;
	int mismatches;
	int reg_writes;

	stim_row_t directed_rows [N_ROWS] = '{
		'{ROW_ITEM, REG_SIZE_X, 32'h0, 24'sd0, 24'sd0, 24'sd0, 1'b1,
			'{8'd4, 8'd4, 8'd4, 8'd0, 8'd0, 8'd0}},
		'{ROW_ITEM, REG_SIZE_X, 32'h0, -24'sd1, -24'sd1, -24'sd1, 1'b1,
			'{8'd3, 8'd3, 8'd3, 8'd12, 8'd12, 8'd12}},
		'{ROW_ITEM, REG_SIZE_X, 32'h0, 24'sd12, 24'sd13, -24'sd13, 1'b1,
			'{8'd4, 8'd5, 8'd3, 8'd12, 8'd0, 8'd0}},
		'{ROW_ITEM, REG_SIZE_X, 32'h0, C_MAX, C_MIN, C_MAX, 1'b0, '0},
		'{ROW_ITEM, REG_SIZE_X, 32'h0, C_MIN, C_MAX, -24'sd2, 1'b0, '0},
		'{ROW_ITEM, REG_SIZE_X, 32'h0, 24'sd1234567, -24'sd7654321, 24'sd117, 1'b0, '0},
		'{ROW_WRITE, REG_SIZE_X, 32'h0000_0000, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_WRITE, REG_SIZE_Y, 32'hABCD_0000, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_WRITE, REG_SIZE_Z, 32'hFFFF_FF00, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_WRITE, REG_RING_X, 32'h0000_0000, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_WRITE, REG_RING_Y, 32'h0000_0100, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_WRITE, REG_RING_Z, 32'h1234_5600, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_ITEM, REG_SIZE_X, 32'h0, C_MAX, C_MIN, 24'sd5, 1'b1, '0},
		'{ROW_ITEM, REG_SIZE_X, 32'h0, -24'sd1, 24'sd0, C_MIN, 1'b1, '0},
		'{ROW_WRITE, REG_NONE_A, 32'h0000_0007, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_WRITE, REG_NONE_B, 32'hFFFF_FFFF, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_ITEM, REG_SIZE_X, 32'h0, 24'sd100, -24'sd100, 24'sd3, 1'b1, '0},
		'{ROW_WRITE, REG_SIZE_X, 32'hFFFF_FF01, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_WRITE, REG_SIZE_Y, 32'h0000_0001, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_WRITE, REG_SIZE_Z, 32'h0000_0001, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_WRITE, REG_RING_X, 32'h0000_00FF, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_WRITE, REG_RING_Y, 32'hFFFF_FFFF, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_WRITE, REG_RING_Z, 32'h0000_00FF, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_ITEM, REG_SIZE_X, 32'h0, 24'sd0, 24'sd0, 24'sd0, 1'b1,
			'{8'd127, 8'd127, 8'd127, 8'd0, 8'd0, 8'd0}},
		'{ROW_ITEM, REG_SIZE_X, 32'h0, 24'sd127, 24'sd128, -24'sd127, 1'b1,
			'{8'd254, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}},
		'{ROW_ITEM, REG_SIZE_X, 32'h0, C_MAX, C_MIN, -24'sd128, 1'b0, '0},
		'{ROW_WRITE, REG_SIZE_X, 32'h0000_00FF, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_WRITE, REG_SIZE_Y, 32'h0000_00FF, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_WRITE, REG_SIZE_Z, 32'h0000_00FF, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_WRITE, REG_RING_X, 32'h0000_0001, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_WRITE, REG_RING_Y, 32'h0000_0001, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_WRITE, REG_RING_Z, 32'h0000_0001, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_ITEM, REG_SIZE_X, 32'h0, 24'sd254, 24'sd255, -24'sd1, 1'b1,
			'{8'd0, 8'd0, 8'd0, 8'd254, 8'd0, 8'd254}},
		'{ROW_ITEM, REG_SIZE_X, 32'h0, C_MAX, C_MIN, 24'sd256, 1'b0, '0},
		'{ROW_WRITE, REG_RING_X, 32'h0000_00FF, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_WRITE, REG_RING_Y, 32'h0000_00FF, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_WRITE, REG_RING_Z, 32'h0000_00FF, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_ITEM, REG_SIZE_X, 32'h0, 24'sd0, -24'sd1, 24'sd65025, 1'b0, '0},
		'{ROW_ITEM, REG_SIZE_X, 32'h0, C_MIN, C_MAX, 24'sd12345, 1'b0, '0},
		'{ROW_WRITE, REG_SIZE_X, 32'h0000_0002, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_WRITE, REG_SIZE_Y, 32'h0000_0003, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_WRITE, REG_SIZE_Z, 32'h0000_0007, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_WRITE, REG_RING_X, 32'h0000_0002, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_WRITE, REG_RING_Y, 32'h0000_0003, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_WRITE, REG_RING_Z, 32'h0000_0004, 24'sd0, 24'sd0, 24'sd0, 1'b0, '0},
		'{ROW_ITEM, REG_SIZE_X, 32'h0, -24'sd3, 24'sd5, -24'sd8, 1'b0, '0},
		'{ROW_ITEM, REG_SIZE_X, 32'h0, 24'sd7, -24'sd9, 24'sd8, 1'b0, '0}
	};

	function automatic chunk_addr_t map_coord(coord_t x, coord_t y, coord_t z);
		coord_t crd [3];
		logic [SW-1:0] slot [3];
		logic [SW-1:0] offs [3];
		longint a, c, n, q, r, m;
		chunk_addr_t res;
		crd[0] = x;
		crd[1] = y;
		crd[2] = z;
		for (int i = 0; i < 3; i++) begin
			a = longint'(crd[i]);
			c = (chunk_len[i] == '0) ? 64'sd1 : longint'(chunk_len[i]);
			n = (ring_len[i] == '0) ? 64'sd1 : longint'(ring_len[i]);
			q = a / c;
			r = a % c;
			if (r < 0) begin
				r = r + c;
				q = q - 1;
			end
			m = (q + n / 2) % n;
			if (m < 0) begin
				m = m + n;
			end
			slot[i] = m[SW-1:0];
			offs[i] = r[SW-1:0];
		end
		res.slot_x   = slot[0];
		res.slot_y   = slot[1];
		res.slot_z   = slot[2];
		res.offset_x = offs[0];
		res.offset_y = offs[1];
		res.offset_z = offs[2];
		return res;
	endfunction

	function automatic coord_t pick_coord(int axis);
		longint c, n, v;
		c = (chunk_len[axis] == '0) ? 64'sd1 : longint'(chunk_len[axis]);
		n = (ring_len[axis] == '0) ? 64'sd1 : longint'(ring_len[axis]);
		case ($urandom_range(0, 5))
			2: begin
				v = longint'($urandom_range(0, 4 * c * n)) - 2 * c * n;
			end
			3: begin
				if ($urandom_range(0, 1)) begin
					v = 64'sd8388607 - longint'($urandom_range(0, c));
				end else begin
					v = -64'sd8388608 + longint'($urandom_range(0, c));
				end
			end
			4: begin
				v = (longint'($urandom_range(0, 4 * n)) - 2 * n) * c
					+ longint'($urandom_range(0, 2)) - 1;
			end
			default: begin
				v = longint'($urandom());
			end
		endcase
		return v[CW-1:0];
	endfunction

	function automatic logic [31:0] pick_reg_value();
		logic [SW-1:0] v;
		case ($urandom_range(0, 9))
			0: v = 8'd0;
			1, 2: v = 8'd1;
			3: v = 8'd255;
			4: v = 8'd2;
			default: v = SW'($urandom_range(1, 255));
		endcase
		if ($urandom_range(0, 3) == 0) begin
			return ($urandom() & 32'hFFFF_FF00) | 32'(v);
		end
		return 32'(v);
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z:
				chunk_len[2'(idx - REG_SIZE_X)] = data[SW-1:0];
			REG_RING_X, REG_RING_Y, REG_RING_Z:
				ring_len[2'(idx - REG_RING_X)] = data[SW-1:0];
			default: ;
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	task automatic push_coord(coord_t x, coord_t y, coord_t z, logic typed, chunk_addr_t want);
		chunk_addr_t exp_addr;
		exp_addr = typed ? want : map_coord(x, y, z);
		while ($urandom_range(0, 99) < src_idle) begin
			coord_bus.valid <= 1'b0;
			@(posedge clk);
		end
		coord_bus.valid   <= 1'b1;
		coord_bus.coord_x <= x;
		coord_bus.coord_y <= y;
		coord_bus.coord_z <= z;
		do @(posedge clk); while (!coord_bus.ready);
		addr_exp_q.push_back(exp_addr);
		coords_sent++;
	endtask

	task automatic settle();
		coord_bus.valid <= 1'b0;
		do @(posedge clk); while (addr_exp_q.size() != 0);
	endtask

	always @(posedge clk or negedge arst_n) begin : addr_monitor
		chunk_addr_t got;
		chunk_addr_t want;
		if (!arst_n) begin
			addr_bus.ready <= 1'b0;
		end else begin
			if (addr_bus.valid && addr_bus.ready) begin
				got = {addr_bus.slot_x, addr_bus.slot_y, addr_bus.slot_z,
					addr_bus.offset_x, addr_bus.offset_y, addr_bus.offset_z};
				if (addr_exp_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: unexpected transfer slot %0d/%0d/%0d offset %0d/%0d/%0d",
							$time, got.slot_x, got.slot_y, got.slot_z,
							got.offset_x, got.offset_y, got.offset_z);
					end
				end else begin
					want = addr_exp_q.pop_front();
					addrs_checked++;
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("%0t: slot %0d/%0d/%0d offset %0d/%0d/%0d, ",
								$time, got.slot_x, got.slot_y, got.slot_z,
								got.offset_x, got.offset_y, got.offset_z);
							$display("expected slot %0d/%0d/%0d offset %0d/%0d/%0d",
								want.slot_x, want.slot_y, want.slot_z,
								want.offset_x, want.offset_y, want.offset_z);
						end
					end
				end
			end
			addr_bus.ready <= ($urandom_range(0, 99) >= snk_idle);
		end
	end

	initial begin
		#(12 * 400000);
		$display("toroidal_chunk_address_unit_test: done, errors");
		$finish;
	end

	initial begin
		int src_pct [3];
		int snk_pct [3];
		src_pct = '{38, 79, 0};
		snk_pct = '{79, 38, 0};
		src_idle = src_pct[0];
		snk_idle = snk_pct[0];
		coords_sent   = 0;
		addrs_checked = 0;
		mismatches    = 0;
		reg_writes    = 0;
		for (int i = 0; i < 3; i++) begin
			chunk_len[i] = CHUNK_SIZE_RST;
			ring_len[i]  = RING_CHUNKS_RST;
		end
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		coord_bus.valid   = 1'b0;
		coord_bus.coord_x = '0;
		coord_bus.coord_y = '0;
		coord_bus.coord_z = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				settle();
				write_reg(directed_rows[i].reg_idx, directed_rows[i].wdata);
			end else begin
				push_coord(directed_rows[i].cx, directed_rows[i].cy, directed_rows[i].cz,
					directed_rows[i].typed, directed_rows[i].want);
			end
		end

		for (int ph = 0; ph < 3; ph++) begin
			src_idle = src_pct[ph];
			snk_idle = snk_pct[ph];
			for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
				settle();
				write_reg(REG_SIZE_X, pick_reg_value());
				write_reg(REG_SIZE_Y, pick_reg_value());
				write_reg(REG_SIZE_Z, pick_reg_value());
				write_reg(REG_RING_X, pick_reg_value());
				write_reg(REG_RING_Y, pick_reg_value());
				write_reg(REG_RING_Z, pick_reg_value());
				if ($urandom_range(0, 3) == 0) begin
					write_reg($urandom_range(0, 1) ? REG_NONE_A : REG_NONE_B, $urandom());
				end
				for (int k = 0; k < ITEMS_PER_SETTING; k++) begin
					push_coord(pick_coord(0), pick_coord(1), pick_coord(2), 1'b0, '0);
				end
			end
		end

		settle();
		repeat (2 * PIPE_LAT) @(posedge clk);

		$display("%0d coordinates sent, %0d addresses checked, %0d mismatches",
			coords_sent, addrs_checked, mismatches);
		$display("%0d register writes, including zero, full-scale and unmapped registers",
			reg_writes);
		if (mismatches == 0 && addr_exp_q.size() == 0) begin
			$display("toroidal_chunk_address_unit_test: done, clean");
		end else begin
			$display("toroidal_chunk_address_unit_test: done, errors");
		end
		$finish;
	end

endmodule
